@@ design/lr_pkg.sv @@
// lr_pkg: shared types and constants for the line rasterizer.
// No dependencies.
package lr_pkg;

   localparam int MAX_DIM   = 64;
   localparam int COORD_W   = 12;
   localparam int PIX_W     = $clog2(MAX_DIM);
   localparam int DIM_W     = 7;
   localparam int DELTA_W   = PIX_W + 1;
   localparam int ERR_W     = PIX_W + 3;

   localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(MAX_DIM);

   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN
   } state_type;

endpackage

@@ design/line_rasterizer.sv @@
// line_rasterizer: Bresenham line walker, one pixel result per cycle while rsp_stall is low.
// Depends on lr_pkg.
// A transferred request is checked, then set up, before its first pixel is shown.
// The walk gives major-axis length + 1 pixels, one per cycle while rsp_stall is low,
// stepped by the shared error-term adder; req_stall stays high while a line is walked.
// Dropped commands are accepted and leave the block idle.
// Reset is synchronous, active high; canvas registers return to 64 by 64.
module line_rasterizer
   import lr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_x_begin,
   input  logic signed [COORD_W-1:0] req_y_begin,
   input  logic signed [COORD_W-1:0] req_x_end,
   input  logic signed [COORD_W-1:0] req_y_end,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [PIX_W-1:0]          rsp_pixel_x,
   output logic [PIX_W-1:0]          rsp_pixel_y,
   output logic                      rsp_last_pixel,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_index,
   input  logic [DIM_W-1:0]          csr_data
);

   state_type state_ff, state_in;

   logic [DIM_W-1:0] width_ff, height_ff;
   logic [PIX_W-1:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic [PIX_W-1:0] major_ff, minor_ff, stop_ff;
   logic             ymaj_ff, dir_neg_ff;
   logic signed [ERR_W-1:0] err_ff, inc_lo_ff, inc_hi_ff;

   logic [DIM_W-1:0] w_lim, h_lim;
   logic             cmd_ok;
   logic             req_xfer, rsp_xfer;

   logic signed [DELTA_W-1:0] dx, dy;
   logic [PIX_W-1:0]          adx, ady, maj_len, min_len;
   logic                      ymaj, rev;
   logic [PIX_W-1:0]          s_major, s_minor, e_major, e_minor;
   logic                      step_minor;
   logic signed [ERR_W-1:0]   err_sum;

   function automatic logic in_range(input logic signed [COORD_W-1:0] c,
                                     input logic [DIM_W-1:0] lim);
      return !c[COORD_W-1] && (c[COORD_W-2:0] < (COORD_W-1)'(lim));
   endfunction

   assign csr_ready = 1'b1;
   assign w_lim = (width_ff  > DIM_LIMIT) ? DIM_LIMIT : width_ff;
   assign h_lim = (height_ff > DIM_LIMIT) ? DIM_LIMIT : height_ff;
   assign cmd_ok = in_range(req_x_begin, w_lim) && in_range(req_x_end, w_lim) &&
                   in_range(req_y_begin, h_lim) && in_range(req_y_end, h_lim);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_RUN);
   assign rsp_xfer  = rsp_valid && !rsp_stall;

   assign rsp_pixel_x    = ymaj_ff ? minor_ff : major_ff;
   assign rsp_pixel_y    = ymaj_ff ? major_ff : minor_ff;
   assign rsp_last_pixel = (major_ff == stop_ff);

   // setup of the normalized walk: major axis increasing from the start point
   always_comb begin
      dx  = DELTA_W'({1'b0, x2_ff}) - DELTA_W'({1'b0, x1_ff});
      dy  = DELTA_W'({1'b0, y2_ff}) - DELTA_W'({1'b0, y1_ff});
      adx = dx[DELTA_W-1] ? PIX_W'(-dx) : PIX_W'(dx);
      ady = dy[DELTA_W-1] ? PIX_W'(-dy) : PIX_W'(dy);
      ymaj = (ady > adx);
      rev  = ymaj ? dy[DELTA_W-1] : dx[DELTA_W-1];
      maj_len = ymaj ? ady : adx;
      min_len = ymaj ? adx : ady;
      s_major = ymaj ? (rev ? y2_ff : y1_ff) : (rev ? x2_ff : x1_ff);
      s_minor = ymaj ? (rev ? x2_ff : x1_ff) : (rev ? y2_ff : y1_ff);
      e_major = ymaj ? (rev ? y1_ff : y2_ff) : (rev ? x1_ff : x2_ff);
      e_minor = ymaj ? (rev ? x1_ff : x2_ff) : (rev ? y1_ff : y2_ff);
   end

   // shared error-term adder
   assign step_minor = ymaj_ff ? (err_ff > 0) : !err_ff[ERR_W-1];
   assign err_sum    = err_ff + (step_minor ? inc_hi_ff : inc_lo_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_xfer && cmd_ok) state_in = ST_SETUP;
         ST_SETUP: state_in = ST_RUN;
         ST_RUN:   if (rsp_xfer && rsp_last_pixel) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_LIMIT;
         height_ff <= DIM_LIMIT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IDX_WIDTH:  width_ff  <= csr_data;
            CSR_IDX_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         x1_ff <= req_x_begin[PIX_W-1:0];
         y1_ff <= req_y_begin[PIX_W-1:0];
         x2_ff <= req_x_end[PIX_W-1:0];
         y2_ff <= req_y_end[PIX_W-1:0];
      end
      if (state_ff == ST_SETUP) begin
         major_ff   <= s_major;
         minor_ff   <= s_minor;
         stop_ff    <= e_major;
         ymaj_ff    <= ymaj;
         dir_neg_ff <= (e_minor < s_minor);
         err_ff     <= ERR_W'({min_len, 1'b0}) - ERR_W'(maj_len);
         inc_lo_ff  <= ERR_W'({min_len, 1'b0});
         inc_hi_ff  <= ERR_W'({min_len, 1'b0}) - ERR_W'({maj_len, 1'b0});
      end else if (rsp_xfer && !rsp_last_pixel) begin
         major_ff <= major_ff + PIX_W'(1);
         err_ff   <= err_sum;
         if (step_minor) begin
            minor_ff <= dir_neg_ff ? (minor_ff - PIX_W'(1)) : (minor_ff + PIX_W'(1));
         end
      end
   end

   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("result valid while accepting requests");

   a_major_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (major_ff <= stop_ff))
      else $error("walk passed its end point");

   a_major_step: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !rsp_last_pixel |=> rsp_valid && (major_ff == $past(major_ff) + PIX_W'(1)))
      else $error("major axis did not advance by one");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_last_pixel |=> !rsp_valid && !req_stall)
      else $error("block did not return to idle after last pixel");

endmodule
